// File: design/lz78de_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78de_pkg
// Shared constants and types for the LZ78 dictionary build and encode unit.
// ----------------------------------------------------------------------------

package lz78de_pkg;

  // default number of dictionary codes
  localparam int unsigned DICT_SIZE_DEFAULT = 4096;

  // first code past the single-byte codes
  localparam int unsigned FIRST_PHRASE_CODE = 256;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CODEWORD_W = 12;

  // output tdata is padded to whole bytes
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned IN_TDATA_W  = 8;

  // configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_MODE = 3'd0;

  // mode register values
  localparam logic MODE_TRAIN  = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE
  } state_t;

endpackage

// File: design/lz78_dictionary_build_and_encode_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78_dictionary_build_and_encode_unit
// LZ78 phrase dictionary builder and greedy phrase encoder.
// ----------------------------------------------------------------------------
//
//  channel   | dir | transaction carries
//  ----------+-----+-------------------------------------------------------
//  s_*       | in  | tdata[7:0] data_byte, tlast end_of_stream
//  m_*       | out | tdata[11:0] codeword (upper bits zero), tlast final_code
//  APB       | in  | register 0 at byte address 0: mode (bit 0)
//
//  Flow: a byte that opens a phrase (or is dropped on a full dictionary)
//  is done in its accept cycle. A byte that extends a phrase then probes the
//  child table by hash (one read port, one probe each cycle) until a key
//  match or an empty slot ends the run.
//  Reset: after rst the child table is swept to empty, one entry a cycle,
//  over all 2**($clog2(DICT_SIZE)+1) slots (8192 at the default); s_tready stays low.
//  Stalls: results sit in a two-entry output queue, so m_tready low does not
//  hold off the input until the queue lacks room for an item's results.
//
//  Dictionary store: an open-addressed hash table keyed by (parent code,
//  byte), twice the code count in size so a probe run always hits an empty
//  slot. Each slot holds {child code, parent code, byte}; child code zero
//  marks an empty slot, since phrase codes start at 256. Pairs are unique,
//  so the first key match is the child.
// ----------------------------------------------------------------------------

module lz78_dictionary_build_and_encode_unit #(
  parameter int unsigned DICT_SIZE = lz78de_pkg::DICT_SIZE_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,

  // slave stream
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [lz78de_pkg::IN_TDATA_W-1:0]       s_tdata,   // [7:0] data_byte
  input  logic                                    s_tlast,   // end_of_stream

  // master stream
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [lz78de_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [11:0] codeword
  output logic                                    m_tlast,   // final_code

  // configuration
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [lz78de_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [lz78de_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [lz78de_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                    pready
);

  // code width, hash index width, slot width
  localparam int unsigned CW    = $clog2(DICT_SIZE);
  localparam int unsigned NW    = CW + 1;
  localparam int unsigned HW    = CW + 1;
  localparam int unsigned KW    = CW + lz78de_pkg::BYTE_W;
  localparam int unsigned EW    = CW + KW;
  localparam int unsigned HSIZE = 2 ** HW;
  localparam int unsigned BW    = lz78de_pkg::BYTE_W;
  localparam int unsigned OW    = lz78de_pkg::CODEWORD_W;

  localparam logic [NW-1:0] DICT_LIMIT = NW'(DICT_SIZE);
  localparam logic [NW-1:0] FIRST_CODE = NW'(lz78de_pkg::FIRST_PHRASE_CODE);
  localparam logic [HW-1:0] LAST_SLOT  = HW'(HSIZE - 1);

  // fold the (parent, byte) key into a table index
  function automatic logic [HW-1:0] slot_hash(input logic [CW-1:0] parent,
                                              input logic [BW-1:0] sym);
    logic [KW-1:0] key;
    key = {parent, sym};
    return key[HW-1:0] ^ HW'(key >> HW);
  endfunction

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  lz78de_pkg::state_t state, state_next;

  logic            mode;
  logic [NW-1:0]   next_code, next_code_next;
  logic [CW-1:0]   cur_code,  cur_code_next;
  logic            at_root,   at_root_next;
  logic [HW-1:0]   clr_addr;
  logic [HW-1:0]   probe,     probe_next;
  logic [BW-1:0]   in_byte;
  logic            in_eos;

  // child table
  logic [EW-1:0]   table_mem [HSIZE];
  logic [EW-1:0]   rd_data;
  logic            mem_re;
  logic [HW-1:0]   mem_ra;
  logic            mem_we;
  logic [HW-1:0]   mem_wa;
  logic [EW-1:0]   mem_wd;

  // output queue, entry 0 is the head
  logic [OW-1:0]   q_code [2];
  logic            q_fin  [2];
  logic [1:0]      q_cnt;
  logic [OW-1:0]   q_code_next [2];
  logic            q_fin_next  [2];
  logic [1:0]      q_cnt_next;

  logic [1:0]      push_n;
  logic [OW-1:0]   push0_code, push1_code;
  logic            push0_fin,  push1_fin;

  logic            cfg_write;
  logic            accept;
  logic            pop;
  logic            dict_full;

  // slot fields
  logic [BW-1:0]   rd_byte;
  logic [CW-1:0]   rd_parent;
  logic [CW-1:0]   rd_child;
  logic            rd_empty;
  logic            rd_hit;

  assign rd_byte   = rd_data[BW-1:0];
  assign rd_parent = rd_data[KW-1:BW];
  assign rd_child  = rd_data[EW-1:KW];
  assign rd_empty  = (rd_child == '0);
  assign rd_hit    = !rd_empty && (rd_parent == cur_code) && (rd_byte == in_byte);

  assign dict_full = (next_code >= DICT_LIMIT);
  assign s_tready  = (state == lz78de_pkg::ST_IDLE) && (q_cnt != 2'd2);
  assign accept    = s_tvalid && s_tready;
  assign pop       = m_tvalid && m_tready;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr == lz78de_pkg::ADDR_MODE) begin
      prdata[0] = mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= lz78de_pkg::MODE_TRAIN;
    end else if (cfg_write && paddr == lz78de_pkg::ADDR_MODE) begin
      mode <= pwdata[0];
    end
  end

  // --------------------------------------------------------------------------
  // control: next state, table access, results
  // --------------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    next_code_next = next_code;
    cur_code_next  = cur_code;
    at_root_next   = at_root;
    probe_next     = probe;
    mem_re         = 1'b0;
    mem_ra         = probe;
    mem_we         = 1'b0;
    mem_wa         = probe;
    mem_wd         = {cur_code, cur_code, in_byte};
    push_n         = 2'd0;
    push0_code     = OW'(cur_code);
    push0_fin      = 1'b0;
    push1_code     = OW'(in_byte);
    push1_fin      = 1'b1;

    unique case (state)
      lz78de_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = '0;
        if (clr_addr == LAST_SLOT) begin
          state_next = lz78de_pkg::ST_IDLE;
        end
      end

      lz78de_pkg::ST_IDLE: begin
        if (accept) begin
          if (mode == lz78de_pkg::MODE_TRAIN && dict_full) begin
            // dictionary full: byte ignored, only the end mark acts
            if (s_tlast) begin
              cur_code_next = '0;
              at_root_next  = 1'b1;
            end
          end else if (at_root) begin
            if (s_tlast) begin
              cur_code_next = '0;
              at_root_next  = 1'b1;
              if (mode == lz78de_pkg::MODE_ENCODE) begin
                push_n     = 2'd1;
                push0_code = OW'(s_tdata[BW-1:0]);
                push0_fin  = 1'b1;
              end
            end else begin
              cur_code_next = CW'(s_tdata[BW-1:0]);
              at_root_next  = 1'b0;
            end
          end else begin
            mem_re     = 1'b1;
            mem_ra     = slot_hash(cur_code, s_tdata[BW-1:0]);
            probe_next = mem_ra;
            state_next = lz78de_pkg::ST_PROBE;
          end
        end
      end

      lz78de_pkg::ST_PROBE: begin
        if (rd_hit) begin
          if (mode == lz78de_pkg::MODE_ENCODE && in_eos) begin
            // phrase ends with the stream
            if (q_cnt != 2'd2) begin
              push_n        = 2'd1;
              push0_code    = OW'(rd_child);
              push0_fin     = 1'b1;
              cur_code_next = '0;
              at_root_next  = 1'b1;
              state_next    = lz78de_pkg::ST_IDLE;
            end
          end else begin
            cur_code_next = rd_child;
            if (in_eos) begin
              cur_code_next = '0;
              at_root_next  = 1'b1;
            end
            state_next = lz78de_pkg::ST_IDLE;
          end
        end else if (rd_empty) begin
          if (mode == lz78de_pkg::MODE_TRAIN) begin
            // new phrase takes the next code, walk restarts
            mem_we         = 1'b1;
            mem_wa         = probe;
            mem_wd         = {next_code[CW-1:0], cur_code, in_byte};
            next_code_next = next_code + NW'(1);
            cur_code_next  = '0;
            at_root_next   = 1'b1;
            state_next     = lz78de_pkg::ST_IDLE;
          end else if (in_eos) begin
            // break and end together: matched phrase, then the byte alone
            if (q_cnt == 2'd0) begin
              push_n        = 2'd2;
              push0_code    = OW'(cur_code);
              push0_fin     = 1'b0;
              push1_code    = OW'(in_byte);
              push1_fin     = 1'b1;
              cur_code_next = '0;
              at_root_next  = 1'b1;
              state_next    = lz78de_pkg::ST_IDLE;
            end
          end else begin
            // break: emit match, byte opens the next phrase
            if (q_cnt != 2'd2) begin
              push_n        = 2'd1;
              push0_code    = OW'(cur_code);
              push0_fin     = 1'b0;
              cur_code_next = CW'(in_byte);
              state_next    = lz78de_pkg::ST_IDLE;
            end
          end
        end else begin
          // slot taken by another key: linear probe
          mem_re     = 1'b1;
          mem_ra     = probe + HW'(1);
          probe_next = mem_ra;
        end
      end

      default: begin
        state_next = lz78de_pkg::ST_CLEAR;
      end
    endcase

    // a mode write drops any open phrase
    if (cfg_write && paddr == lz78de_pkg::ADDR_MODE) begin
      cur_code_next = '0;
      at_root_next  = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // output queue update: pop, then append in order
  // --------------------------------------------------------------------------
  always_comb begin
    logic [1:0] base;
    q_code_next[0] = q_code[0];
    q_code_next[1] = q_code[1];
    q_fin_next[0]  = q_fin[0];
    q_fin_next[1]  = q_fin[1];
    base           = q_cnt;
    if (pop) begin
      q_code_next[0] = q_code[1];
      q_fin_next[0]  = q_fin[1];
      base           = q_cnt - 2'd1;
    end
    if (push_n != 2'd0) begin
      q_code_next[base[0]] = push0_code;
      q_fin_next[base[0]]  = push0_fin;
    end
    if (push_n == 2'd2) begin
      q_code_next[1] = push1_code;
      q_fin_next[1]  = push1_fin;
    end
    q_cnt_next = base + push_n;
  end

  assign m_tvalid = (q_cnt != 2'd0);
  assign m_tdata  = lz78de_pkg::OUT_TDATA_W'(q_code[0]);
  assign m_tlast  = q_fin[0];

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lz78de_pkg::ST_CLEAR;
      next_code <= FIRST_CODE;
      cur_code  <= '0;
      at_root   <= 1'b1;
      clr_addr  <= '0;
      q_cnt     <= 2'd0;
    end else begin
      state     <= state_next;
      next_code <= next_code_next;
      cur_code  <= cur_code_next;
      at_root   <= at_root_next;
      q_cnt     <= q_cnt_next;
      if (state == lz78de_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    probe     <= probe_next;
    q_code[0] <= q_code_next[0];
    q_code[1] <= q_code_next[1];
    q_fin[0]  <= q_fin_next[0];
    q_fin[1]  <= q_fin_next[1];
    if (accept) begin
      in_byte <= s_tdata[BW-1:0];
      in_eos  <= s_tlast;
    end
  end

  // child table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= table_mem[mem_ra];
    end
  end

endmodule

// File: dv/lz78_dictionary_build_and_encode_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78_dictionary_build_and_encode_unit_test
// Self-checking bench for the LZ78 dictionary build and encode unit. A
// clocked driver feeds bytes from a queue and a clocked monitor drains the
// codeword stream. Each accepted byte runs through a local dictionary model
// that builds the expected codewords. The run covers directed corner streams,
// random train and encode streams on small and full dictionaries, random
// stalls on both streams, and mode writes over the APB port.
// ----------------------------------------------------------------------------

module lz78_dictionary_build_and_encode_unit_test;

  // Smallest legal dictionary, so the full-dictionary behavior is reachable.
  localparam int TB_DICT_SIZE  = 512;
  localparam int CODE_W        = $clog2(TB_DICT_SIZE);
  // Cycles left for a lookup that ends in no codeword before a mode write.
  localparam int SETTLE_CYCLES = 32;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int LONG_HOLD     = 400;

  typedef struct packed {
    logic [lz78de_pkg::BYTE_W-1:0] data_byte;
    logic                          end_of_stream;
  } stream_byte_t;

  typedef struct packed {
    logic [lz78de_pkg::CODEWORD_W-1:0] codeword;
    logic                              final_code;
  } code_result_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  s_tvalid = 1'b0;
  logic                                  s_tready;
  logic [lz78de_pkg::IN_TDATA_W-1:0]     s_tdata = '0;   // [7:0] data_byte
  logic                                  s_tlast = 1'b0; // end_of_stream
  logic                                  m_tvalid;
  logic                                  m_tready = 1'b0;
  logic [lz78de_pkg::OUT_TDATA_W-1:0]    m_tdata;        // [11:0] codeword, [15:12] zero
  logic                                  m_tlast;        // final_code
  logic                                  psel = 1'b0;
  logic                                  penable = 1'b0;
  logic                                  pwrite = 1'b0;
  logic [lz78de_pkg::APB_ADDR_W-1:0]     paddr = '0;
  logic [lz78de_pkg::APB_DATA_W-1:0]     pwdata = '0;
  logic [lz78de_pkg::APB_DATA_W-1:0]     prdata;
  logic                                  pready;

  lz78_dictionary_build_and_encode_unit #(
    .DICT_SIZE(TB_DICT_SIZE)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Dictionary model: phrase table, walk state and mode register copy.
  // --------------------------------------------------------------------------
  logic [CODE_W-1:0]             parent_code [TB_DICT_SIZE];
  logic [lz78de_pkg::BYTE_W-1:0] last_sym    [TB_DICT_SIZE];
  int                            dict_next    = lz78de_pkg::FIRST_PHRASE_CODE;
  logic [CODE_W-1:0]             walk_code    = '0;
  logic                          walk_at_root = 1'b1;
  logic                          cfg_mode     = lz78de_pkg::MODE_TRAIN;

  stream_byte_t pending_bytes [$];
  code_result_t expected_codes [$];

  int err_cnt       = 0;
  int n_accepted    = 0;
  int n_checked     = 0;
  int n_mode_writes = 0;
  bit idle_en       = 1'b0;   // random gaps on both streams
  int hold_req      = 0;      // bumped to ask the monitor for one long stall

  // Linear search over the codes in use; pairs are unique so first hit wins.
  function automatic bit find_child(input logic [lz78de_pkg::BYTE_W-1:0] sym,
                                    output logic [CODE_W-1:0] child);
    child = '0;
    for (int c = lz78de_pkg::FIRST_PHRASE_CODE; c < dict_next; c++) begin
      if (parent_code[c] == walk_code && last_sym[c] == sym) begin
        child = CODE_W'(c);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_codes(input logic [lz78de_pkg::BYTE_W-1:0] sym,
                               input logic eos);
    logic [CODE_W-1:0] child;
    bit                hit;
    code_result_t      res;
    hit = find_child(sym, child);
    if (cfg_mode == lz78de_pkg::MODE_TRAIN) begin
      // full dictionary: bytes are dropped, only end of stream still acts
      if (dict_next < TB_DICT_SIZE) begin
        if (walk_at_root) begin
          walk_code    = CODE_W'(sym);
          walk_at_root = 1'b0;
        end else if (hit) begin
          walk_code = child;
        end else begin
          parent_code[dict_next] = walk_code;
          last_sym[dict_next]    = sym;
          dict_next++;
          walk_code    = '0;
          walk_at_root = 1'b1;
        end
      end
      if (eos) begin
        walk_code    = '0;
        walk_at_root = 1'b1;
      end
    end else begin
      if (walk_at_root) begin
        walk_code    = CODE_W'(sym);
        walk_at_root = 1'b0;
      end else if (hit) begin
        walk_code = child;
      end else begin
        // match broken: emit it, the breaking byte opens the next phrase
        res = '{lz78de_pkg::CODEWORD_W'(walk_code), 1'b0};
        expected_codes.insert(expected_codes.size(), res);
        walk_code = CODE_W'(sym);
      end
      if (eos) begin
        res = '{lz78de_pkg::CODEWORD_W'(walk_code), 1'b1};
        expected_codes.insert(expected_codes.size(), res);
        walk_code    = '0;
        walk_at_root = 1'b1;
      end
    end
  endtask

  task automatic check_codeword(input logic [lz78de_pkg::OUT_TDATA_W-1:0] tdata,
                                input logic tlast);
    code_result_t want;
    if (expected_codes.size() == 0) begin
      err_cnt++;
      $display("%0t: codeword mismatch: expected none, actual tdata %h tlast %b",
               $time, tdata, tlast);
    end else begin
      want = expected_codes.pop_front();
      n_checked++;
      if (tdata !== lz78de_pkg::OUT_TDATA_W'(want.codeword)) begin
        err_cnt++;
        $display("%0t: codeword mismatch: expected %h, actual %h",
                 $time, lz78de_pkg::OUT_TDATA_W'(want.codeword), tdata);
      end
      if (tlast !== want.final_code) begin
        err_cnt++;
        $display("%0t: final_code mismatch: expected %b, actual %b",
                 $time, want.final_code, tlast);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued bytes, predicts at each accepted transaction.
  // --------------------------------------------------------------------------
  stream_byte_t next_item;
  int           src_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_codes(s_tdata[lz78de_pkg::BYTE_W-1:0], s_tlast);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_item = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_item.data_byte;
          s_tlast  <= next_item.end_of_stream;
          if (idle_en && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 17);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks codewords; random stalls plus one long hold on request.
  // --------------------------------------------------------------------------
  int sink_gap  = 0;
  int hold_left = 0;
  int hold_ack  = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap  = 0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) check_codeword(m_tdata, m_tlast);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 17);
      end
    end
  end

  // --------------------------------------------------------------------------
  // APB access and stimulus helpers
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [lz78de_pkg::APB_ADDR_W-1:0] addr,
                           input logic [lz78de_pkg::APB_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // a mode write also closes the open phrase; the table is kept
    if (addr == lz78de_pkg::ADDR_MODE) begin
      cfg_mode     = data[0];
      walk_code    = '0;
      walk_at_root = 1'b1;
      n_mode_writes++;
    end
  endtask

  task automatic apb_check_mode();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= lz78de_pkg::ADDR_MODE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== lz78de_pkg::APB_DATA_W'(cfg_mode)) begin
      err_cnt++;
      $display("%0t: mode readback mismatch: expected %h, actual %h",
               $time, lz78de_pkg::APB_DATA_W'(cfg_mode), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(input logic value);
    apb_write(lz78de_pkg::ADDR_MODE, lz78de_pkg::APB_DATA_W'(value));
    apb_check_mode();
  endtask

  task automatic push_byte(input logic [lz78de_pkg::BYTE_W-1:0] sym, input logic eos);
    stream_byte_t item;
    item = '{sym, eos};
    pending_bytes.insert(pending_bytes.size(), item);
  endtask

  // letters a..d for pct percent of picks so phrases grow deep, the rest any byte
  function automatic logic [lz78de_pkg::BYTE_W-1:0] pick_symbol(input int pct);
    if ($urandom_range(0, 99) < pct) return 8'h61 + 8'($urandom_range(0, 3));
    return 8'($urandom);
  endfunction

  task automatic push_stream(input int len, input int pct);
    for (int i = 0; i < len; i++) push_byte(pick_symbol(pct), i == len - 1);
  endtask

  // Sender quiet, no codeword outstanding, block back to taking input.
  task automatic wait_idle();
    int spins;
    spins = 0;
    do begin
      @(negedge clk);
      spins++;
    end while ((pending_bytes.size() != 0 || s_tvalid || expected_codes.size() != 0
                || !s_tready) && spins < DRAIN_LIMIT);
    if (pending_bytes.size() != 0 || s_tvalid || expected_codes.size() != 0
        || !s_tready) begin
      err_cnt++;
      $display("%0t: drain stalled: expected %0d more codewords, actual none",
               $time, expected_codes.size());
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // table clearing sweep runs with s_tready low
    do @(negedge clk); while (!s_tready);

    // directed training: "ab"=256, "abc"=257, FF 00=258, "cd"=259
    set_mode(lz78de_pkg::MODE_TRAIN);
    push_byte("a", 1'b0); push_byte("b", 1'b0);
    push_byte("a", 1'b0); push_byte("b", 1'b0); push_byte("c", 1'b0);
    push_byte(8'h00, 1'b1);                     // end of stream drops open phrase
    push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
    push_byte("a", 1'b0);                       // left open, then dropped by the mode write
    wait_idle();
    set_mode(lz78de_pkg::MODE_TRAIN);
    push_byte("c", 1'b0); push_byte("d", 1'b0);
    wait_idle();

    // directed encode
    set_mode(lz78de_pkg::MODE_ENCODE);
    push_byte("a", 1'b0); push_byte("b", 1'b0); push_byte("c", 1'b1);  // 257 last
    push_byte("a", 1'b0); push_byte("b", 1'b0); push_byte("d", 1'b1);  // break and end
    push_byte(8'h00, 1'b1);                                            // lone byte
    push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b1);
    push_byte("q", 1'b0); push_byte("r", 1'b0); push_byte("s", 1'b0);  // "s" left open
    wait_idle();
    set_mode(lz78de_pkg::MODE_ENCODE);
    push_byte("c", 1'b0); push_byte("d", 1'b1);
    wait_idle();

    // random training on a small alphabet, then encode against it
    idle_en = 1'b1;
    set_mode(lz78de_pkg::MODE_TRAIN);
    repeat (8) push_stream($urandom_range(2, 16), 80);
    wait_idle();
    set_mode(lz78de_pkg::MODE_ENCODE);
    repeat (5) push_stream($urandom_range(1, 20), 85);
    wait_idle();                                 // sender pauses until all codes are in
    repeat (4) push_stream($urandom_range(1, 20), 60);
    wait_idle();

    // fill the dictionary with mostly random bytes, then keep training on it
    set_mode(lz78de_pkg::MODE_TRAIN);
    while (dict_next < TB_DICT_SIZE) begin
      repeat (4) push_stream($urandom_range(2, 8), 20);
      wait_idle();
    end
    repeat (3) push_stream($urandom_range(3, 8), 50);
    wait_idle();

    // encode on the full dictionary under one long output stall
    set_mode(lz78de_pkg::MODE_ENCODE);
    hold_req++;
    repeat (6) push_stream($urandom_range(1, 16), 85);
    wait_idle();

    // closing stretch with no idling on either stream
    idle_en = 1'b0;
    set_mode(lz78de_pkg::MODE_ENCODE);
    repeat (3) push_stream($urandom_range(1, 16), 70);
    wait_idle();

    $display("Run covered %0d bytes, %0d codewords checked, %0d mode writes.",
             n_accepted, n_checked, n_mode_writes);
    $display("Dictionary built to %0d of %0d codes; encode ran on partial and full tables.",
             dict_next, TB_DICT_SIZE);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #4_000_000;
    $display("%0t: timeout, run did not finish", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
design/lz78de_pkg.sv
design/lz78_dictionary_build_and_encode_unit.sv
dv/lz78_dictionary_build_and_encode_unit_test.sv
